// ===== src/swept_circle_grid_cell_range_core_defines.svh =====
// Assertion macros for the swept circle grid cell range core
`ifndef SWEPT_CIRCLE_GRID_CELL_RANGE_CORE_DEFINES_SVH
`define SWEPT_CIRCLE_GRID_CELL_RANGE_CORE_DEFINES_SVH
`ifndef SYNTH
// clocked check, disabled while in reset
`define SCR_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scr check failed");
// clocked check that also holds during reset
`define SCR_CHECK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scr check failed");
`else
`define SCR_CHECK(lbl, prop)
`define SCR_CHECK_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/scr_pkg.sv =====
// Types and constants shared by the swept circle grid cell range core
package scr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 12;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    localparam int CELLS_WIDTH = 15;
    localparam int IDX_WIDTH   = 16;
    localparam int ROOT_WIDTH  = COORD_WIDTH;
    localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
    localparam int NUM_WIDTH   = COORD_WIDTH + 3;
    localparam int LANES       = 4;
    localparam int CFG_IDX_WIDTH = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Z    = 3'd1,
        REG_CELL_SIZE_X = 3'd2,
        REG_CELL_SIZE_Z = 3'd3,
        REG_CELLS_X     = 3'd4,
        REG_CELLS_Z     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] centre_x;
        logic signed [COORD_WIDTH-1:0] centre_z;
        logic signed [COORD_WIDTH-1:0] move_x;
        logic signed [COORD_WIDTH-1:0] move_z;
        logic [SIZE_WIDTH-1:0]         circle_radius;
    } req_t;

    typedef struct packed {
        logic [CELLS_WIDTH-1:0]      first_col;
        logic [CELLS_WIDTH-1:0]      first_row;
        logic signed [IDX_WIDTH-1:0] last_col;
        logic signed [IDX_WIDTH-1:0] last_row;
    } res_t;

    // square root chain payload
    typedef struct packed {
        logic [SQ_WIDTH-1:0]           rem;
        logic [ROOT_WIDTH-1:0]         root;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cz;
        logic [SIZE_WIDTH-1:0]         r;
    } sqs_t;

    // divider chain payload: lanes are lo x, lo z, hi x, hi z
    typedef struct packed {
        logic [LANES-1:0][NUM_WIDTH-1:0]  num;
        logic [LANES-1:0][SIZE_WIDTH:0]   rem;
        logic [LANES-1:0][NUM_WIDTH-1:0]  quo;
        logic [LANES-1:0]                 neg;
    } divs_t;

endpackage

// ===== src/swept_circle_grid_cell_range_core.sv =====
// Registers from transfer in to result: stage 1, stage 2, the root cells, stage 3, the divider
// cells and the output; throughput one item per cycle while res_stall is low.
// Each cell advances when it is empty or its successor advances, so bubbles close up.
// Reset (rst_n, asynchronous, active low) empties every stage and loads the register
// reset values: origin 0, cell size 4096, cell count 1.
`include "swept_circle_grid_cell_range_core_defines.svh"
module swept_circle_grid_cell_range_core
    import scr_pkg::*;
#(
    parameter int FRAC_BITS_P = FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  req_t                     req_data,
    output logic                     res_valid,
    input  logic                     res_stall,
    output res_t                     res_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]   cfg_data
);

    // configuration registers
    logic signed [COORD_WIDTH-1:0] origin_x_reg, origin_z_reg;
    logic [SIZE_WIDTH-1:0]         cell_size_x_reg, cell_size_z_reg;
    logic [CELLS_WIDTH-1:0]        cells_x_reg, cells_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_z_reg    <= '0;
            cell_size_x_reg <= SIZE_WIDTH'(4096);
            cell_size_z_reg <= SIZE_WIDTH'(4096);
            cells_x_reg     <= CELLS_WIDTH'(1);
            cells_z_reg     <= CELLS_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Z:    origin_z_reg    <= cfg_data;
                REG_CELL_SIZE_X: cell_size_x_reg <= cfg_data[SIZE_WIDTH-1:0];
                REG_CELL_SIZE_Z: cell_size_z_reg <= cfg_data[SIZE_WIDTH-1:0];
                REG_CELLS_X:     cells_x_reg     <= cfg_data[CELLS_WIDTH-1:0];
                REG_CELLS_Z:     cells_z_reg     <= cfg_data[CELLS_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // zero cell size acts as one
    logic [SIZE_WIDTH-1:0]            size_x, size_z;
    logic [LANES-1:0][SIZE_WIDTH-1:0] divisor;
    assign size_x  = (cell_size_x_reg == '0) ? SIZE_WIDTH'(1) : cell_size_x_reg;
    assign size_z  = (cell_size_z_reg == '0) ? SIZE_WIDTH'(1) : cell_size_z_reg;
    assign divisor = {size_z, size_x, size_z, size_x};

    // stage valids and advance chain
    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg, res_valid_reg;
    logic                  adv1, adv2, adv3, adv_out;
    logic [ROOT_WIDTH-1:0] sq_v, adv_sq;
    logic [NUM_WIDTH-1:0]  dv_v, adv_dv;
    sqs_t                  sq_d [ROOT_WIDTH];
    divs_t                 dv_d [NUM_WIDTH];

    assign adv_out = !res_valid_reg || !res_stall;

    genvar k;
    generate
        for (k = 0; k < NUM_WIDTH; k++)
        begin : g_dv_adv
            if (k == NUM_WIDTH - 1)
            begin : g_last
                assign adv_dv[k] = !dv_v[k] || adv_out;
            end
            else
            begin : g_mid
                assign adv_dv[k] = !dv_v[k] || adv_dv[k+1];
            end
        end
        for (k = 0; k < ROOT_WIDTH; k++)
        begin : g_sq_adv
            if (k == ROOT_WIDTH - 1)
            begin : g_last
                assign adv_sq[k] = !sq_v[k] || adv3;
            end
            else
            begin : g_mid
                assign adv_sq[k] = !sq_v[k] || adv_sq[k+1];
            end
        end
    endgenerate

    assign adv3 = !s3_valid_reg || adv_dv[0];
    assign adv2 = !s2_valid_reg || adv_sq[0];
    assign adv1 = !s1_valid_reg || adv2;
    assign req_stall = !adv1;

    // stage 1: squares of the move magnitudes
    logic [COORD_WIDTH-1:0]        mag_x, mag_z;
    logic [SQ_WIDTH-1:0]           sqx_reg, sqz_reg;
    logic signed [COORD_WIDTH-1:0] cx1_reg, cz1_reg;
    logic [SIZE_WIDTH-1:0]         r1_reg;

    assign mag_x = req_data.move_x[COORD_WIDTH-1] ? -req_data.move_x : req_data.move_x;
    assign mag_z = req_data.move_z[COORD_WIDTH-1] ? -req_data.move_z : req_data.move_z;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            sqx_reg <= SQ_WIDTH'(mag_x) * SQ_WIDTH'(mag_x);
            sqz_reg <= SQ_WIDTH'(mag_z) * SQ_WIDTH'(mag_z);
            cx1_reg <= req_data.centre_x;
            cz1_reg <= req_data.centre_z;
            r1_reg  <= req_data.circle_radius;
        end
    end

    // stage 2: radicand
    sqs_t s2_reg;
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_reg.rem  <= sqx_reg + sqz_reg;
            s2_reg.root <= '0;
            s2_reg.cx   <= cx1_reg;
            s2_reg.cz   <= cz1_reg;
            s2_reg.r    <= r1_reg;
        end
    end

    // square root cell chain, most significant bit first
    generate
        for (k = 0; k < ROOT_WIDTH; k++)
        begin : g_sq
            if (k == 0)
            begin : g_first
                scr_sqrt_cell #(.BIT(ROOT_WIDTH - 1 - k)) u_cell (
                    .clk(clk), .rst_n(rst_n), .adv(adv_sq[k]),
                    .in_valid(s2_valid_reg), .in_data(s2_reg),
                    .out_valid(sq_v[k]), .out_data(sq_d[k])
                );
            end
            else
            begin : g_next
                scr_sqrt_cell #(.BIT(ROOT_WIDTH - 1 - k)) u_cell (
                    .clk(clk), .rst_n(rst_n), .adv(adv_sq[k]),
                    .in_valid(sq_v[k-1]), .in_data(sq_d[k-1]),
                    .out_valid(sq_v[k]), .out_data(sq_d[k])
                );
            end
        end
    endgenerate

    // stage 3: margin, offset bounds, signs and magnitudes
    sqs_t                        sq_last;
    logic signed [NUM_WIDTH-1:0] margin, dx, dz;
    logic signed [NUM_WIDTH-1:0] bnd [LANES];
    divs_t                       s3_next, s3_reg;

    assign sq_last = sq_d[ROOT_WIDTH-1];

    always_comb
    begin
        margin = NUM_WIDTH'(sq_last.root) + NUM_WIDTH'(sq_last.r)
               + (NUM_WIDTH'(1) << FRAC_BITS_P);
        dx = NUM_WIDTH'(sq_last.cx) - NUM_WIDTH'(origin_x_reg);
        dz = NUM_WIDTH'(sq_last.cz) - NUM_WIDTH'(origin_z_reg);
        bnd[0] = dx - margin;
        bnd[1] = dz - margin;
        bnd[2] = dx + margin;
        bnd[3] = dz + margin;
        s3_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            s3_next.neg[i] = bnd[i][NUM_WIDTH-1];
            s3_next.num[i] = bnd[i][NUM_WIDTH-1] ? -bnd[i] : bnd[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_reg <= s3_next;
        end
    end

    // divider cell chain, most significant quotient bit first
    generate
        for (k = 0; k < NUM_WIDTH; k++)
        begin : g_dv
            if (k == 0)
            begin : g_first
                scr_div_cell #(.BIT(NUM_WIDTH - 1 - k)) u_cell (
                    .clk(clk), .rst_n(rst_n), .adv(adv_dv[k]), .divisor(divisor),
                    .in_valid(s3_valid_reg), .in_data(s3_reg),
                    .out_valid(dv_v[k]), .out_data(dv_d[k])
                );
            end
            else
            begin : g_next
                scr_div_cell #(.BIT(NUM_WIDTH - 1 - k)) u_cell (
                    .clk(clk), .rst_n(rst_n), .adv(adv_dv[k]), .divisor(divisor),
                    .in_valid(dv_v[k-1]), .in_data(dv_d[k-1]),
                    .out_valid(dv_v[k]), .out_data(dv_d[k])
                );
            end
        end
    endgenerate

    // output stage: sign, saturation and clamping
    divs_t                       dv_last;
    logic signed [IDX_WIDTH-1:0] idx [LANES];
    logic signed [IDX_WIDTH:0]   cx_lim, cz_lim;
    res_t                        res_next, res_reg;

    assign dv_last = dv_d[NUM_WIDTH-1];
    assign cx_lim  = {2'b00, cells_x_reg};
    assign cz_lim  = {2'b00, cells_z_reg};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (dv_last.neg[i])
            begin
                idx[i] = (dv_last.quo[i] > NUM_WIDTH'(32768)) ? IDX_WIDTH'(16'sh8000)
                       : IDX_WIDTH'(-dv_last.quo[i]);
            end
            else
            begin
                idx[i] = (dv_last.quo[i] > NUM_WIDTH'(32767)) ? IDX_WIDTH'(16'sh7fff)
                       : IDX_WIDTH'(dv_last.quo[i]);
            end
        end
        res_next.first_col = idx[0][IDX_WIDTH-1] ? '0 : idx[0][CELLS_WIDTH-1:0];
        res_next.first_row = idx[1][IDX_WIDTH-1] ? '0 : idx[1][CELLS_WIDTH-1:0];
        res_next.last_col  = ($signed({idx[2][IDX_WIDTH-1], idx[2]}) >= cx_lim)
                           ? IDX_WIDTH'(cx_lim - 17'sd1) : idx[2];
        res_next.last_row  = ($signed({idx[3][IDX_WIDTH-1], idx[3]}) >= cz_lim)
                           ? IDX_WIDTH'(cz_lim - 17'sd1) : idx[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && dv_v[NUM_WIDTH-1])
        begin
            res_reg <= res_next;
        end
    end

    // valid flags of the stages kept here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= req_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= sq_v[ROOT_WIDTH-1];
            end
            if (adv_out)
            begin
                res_valid_reg <= dv_v[NUM_WIDTH-1];
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // sign-extended upper bounds for the limit checks
    logic signed [IDX_WIDTH:0] last_col_ext, last_row_ext;
    assign last_col_ext = {res_data.last_col[IDX_WIDTH-1], res_data.last_col};
    assign last_row_ext = {res_data.last_row[IDX_WIDTH-1], res_data.last_row};

    // checks
    `SCR_CHECK(a_res_held, res_valid && res_stall |=> res_valid && $stable(res_data))
    `SCR_CHECK(a_last_col_lim, res_valid |-> last_col_ext < cx_lim)
    `SCR_CHECK(a_last_row_lim, res_valid |-> last_row_ext < cz_lim)
    `SCR_CHECK_ALWAYS(a_empty_takes, !s1_valid_reg |-> !req_stall)

endmodule

// ===== src/scr_sqrt_cell.sv =====
// One root bit of the pipelined integer square root
module scr_sqrt_cell
    import scr_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  sqs_t in_data,
    output logic out_valid,
    output sqs_t out_data
);

    logic              valid_reg;
    sqs_t              data_reg;
    sqs_t              data_next;
    logic [SQ_WIDTH:0] trial;
    logic              take;

    // trial = 2*root*2^BIT + 2^(2*BIT); root has no bits at or below BIT yet
    always_comb
    begin
        trial = ({{(SQ_WIDTH + 1 - ROOT_WIDTH){1'b0}}, in_data.root} << (BIT + 1))
              | ((SQ_WIDTH + 1)'(1) << (2 * BIT));
        take = {1'b0, in_data.rem} >= trial;
        data_next = in_data;
        if (take)
        begin
            data_next.rem  = in_data.rem - trial[SQ_WIDTH-1:0];
            data_next.root = in_data.root | (ROOT_WIDTH'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/scr_div_cell.sv =====
// One quotient bit of the four-lane restoring divider
module scr_div_cell
    import scr_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic [LANES-1:0][SIZE_WIDTH-1:0] divisor,
    input  logic                             in_valid,
    input  divs_t                            in_data,
    output logic                             out_valid,
    output divs_t                            out_data
);

    logic                valid_reg;
    divs_t               data_reg;
    divs_t               data_next;
    logic [SIZE_WIDTH:0] sh;

    // shift in the next dividend bit, subtract where it fits
    always_comb
    begin
        data_next = in_data;
        sh = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sh = {in_data.rem[i][SIZE_WIDTH-1:0], in_data.num[i][BIT]};
            if (sh >= {1'b0, divisor[i]})
            begin
                data_next.rem[i]      = sh - {1'b0, divisor[i]};
                data_next.quo[i][BIT] = 1'b1;
            end
            else
            begin
                data_next.rem[i] = sh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
